// ----- design/fp2h_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fp2h_pkg
// Shared types and constants for the single to half to single quantiser.
// ----------------------------------------------------------------------------
package fp2h_pkg;

  // Single-precision field limits
  localparam logic [7:0]  SpExpMax     = 8'hFF;
  localparam logic [22:0] SpMantAllOne = 23'h7FFFFF;

  // Half exponent sits this far below the single exponent
  localparam logic [7:0]  HalfBiasDiff = 8'h70;
  // Largest single exponent that still fits a finite half
  localparam logic [7:0]  SpExpOvf     = 8'h8E;
  // Smallest single exponent that can leave a non-zero half
  localparam logic [7:0]  SpExpUnf     = 8'h66;

  localparam logic [4:0]  HalfExpMax   = 5'h1F;
  localparam logic [9:0]  HalfQuietNan = 10'h200;

  // Single exponent of a half subnormal whose leading one is at bit 0
  localparam logic [7:0]  SubExpBase   = 8'd103;
  // Single exponent of a normal half with exponent zero
  localparam logic [7:0]  NormExpBase  = 8'd112;

  // Fast mode keeps the top bits at and above this position
  localparam int unsigned FastDropBits = 13;

  typedef struct packed {
    logic       sign;
    logic [4:0] exponent;
    logic [9:0] mantissa;
  } half_t;

endpackage : fp2h_pkg
`default_nettype wire

// ----- design/fp2h_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fp2h_in_if
// Input channel: one single-precision word per handshake.
// ----------------------------------------------------------------------------
interface fp2h_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;

  modport source (output valid, output value_bits, input ready);
  modport sink   (input valid, input value_bits, output ready);
endinterface : fp2h_in_if
`default_nettype wire

// ----- design/fp2h_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fp2h_out_if
// Output channel: one quantised single-precision word per handshake.
// ----------------------------------------------------------------------------
interface fp2h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;

  modport source (output valid, output result_bits, input ready);
  modport sink   (input valid, input result_bits, output ready);
endinterface : fp2h_out_if
`default_nettype wire

// ----- design/fp2h_shrink.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fp2h_shrink
// Single to half conversion: clip, round to nearest even, truncating
// denormalisation.
// ----------------------------------------------------------------------------
module fp2h_shrink
  import fp2h_pkg::*;
(
  input  logic [31:0] value_i,
  output half_t       half_o
);

  logic              sign;
  logic [7:0]        exp_sp;
  logic [22:0]       mant_sp;
  logic              round_up;
  logic [10:0]       mant_rnd;
  logic signed [7:0] exp_unb;
  logic signed [7:0] exp_adj;
  logic signed [7:0] sub_shift;
  logic [10:0]       sub_mant;

  assign sign    = value_i[31];
  assign exp_sp  = value_i[30:23];
  assign mant_sp = value_i[22:0];

  // Round to nearest, ties to even, at bit 13
  assign round_up  = mant_sp[12] && ((mant_sp[11:0] != 12'd0) || mant_sp[13]);
  assign mant_rnd  = {1'b0, mant_sp[22:13]} + {10'd0, round_up};
  assign exp_unb   = $signed(exp_sp - HalfBiasDiff);
  // A mantissa carry leaves the kept bits at zero and bumps the exponent
  assign exp_adj   = exp_unb + $signed({7'd0, mant_rnd[10]});
  assign sub_shift = 8'sd1 - exp_adj;
  assign sub_mant  = {1'b1, mant_rnd[9:0]} >> sub_shift[3:0];

  always_comb begin
    half_o = '{sign: sign, exponent: 5'd0, mantissa: 10'd0};
    if (exp_sp == SpExpMax) begin
      half_o.exponent = HalfExpMax;
      half_o.mantissa = (mant_sp != 23'd0) ? HalfQuietNan : 10'd0;
    end else if (exp_sp > SpExpOvf) begin
      half_o.exponent = HalfExpMax;
    end else if (exp_sp < SpExpUnf) begin
      // signed zero, already set
    end else if (exp_adj >= $signed({3'd0, HalfExpMax})) begin
      half_o.exponent = HalfExpMax;
    end else if (exp_adj <= 8'sd0) begin
      half_o.mantissa = sub_mant[9:0];
    end else begin
      half_o.exponent = exp_adj[4:0];
      half_o.mantissa = mant_rnd[9:0];
    end
  end

endmodule : fp2h_shrink
`default_nettype wire

// ----- design/fp2h_expand.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fp2h_expand
// Exact half to single expansion with subnormal renormalisation; a NaN comes out with an all-ones mantissa.
// ----------------------------------------------------------------------------
module fp2h_expand
  import fp2h_pkg::*;
(
  input  half_t       half_i,
  output logic [31:0] value_o
);

  logic [3:0]  lead_pos;
  logic [10:0] norm_mant;

  // Position of the leading one of a subnormal mantissa
  always_comb begin
    lead_pos = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (half_i.mantissa[i]) begin
        lead_pos = 4'(i);
      end
    end
  end

  assign norm_mant = {1'b0, half_i.mantissa} << (4'd10 - lead_pos);

  always_comb begin
    value_o = {half_i.sign, 31'd0};
    if (half_i.exponent == 5'd0) begin
      if (half_i.mantissa != 10'd0) begin
        value_o[30:23] = SubExpBase + {4'd0, lead_pos};
        value_o[22:0]  = {norm_mant[9:0], 13'd0};
      end
    end else if (half_i.exponent == HalfExpMax) begin
      value_o[30:23] = SpExpMax;
      value_o[22:0]  = (half_i.mantissa != 10'd0) ? SpMantAllOne : 23'd0;
    end else begin
      value_o[30:23] = NormExpBase + {3'd0, half_i.exponent};
      value_o[22:0]  = {half_i.mantissa, 13'd0};
    end
  end

endmodule : fp2h_expand
`default_nettype wire

// ----- design/fp32_to_fp16_roundtrip_quantizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fp32_to_fp16_roundtrip_quantizer
// Rounds single-precision words to half precision, or in fast mode at bit 13.
// ----------------------------------------------------------------------------
// Each accepted word comes out as the single-precision pattern of its half-
// precision value, one result per word, in order. The block takes one word
// per cycle while the output is taken. An accepted word sits in the input
// register and is then loaded into the result register, from which it can
// be taken at the output. While the output is not taken the result register
// holds and the input register still fills behind it, so at most two words
// wait inside. fast_mode selects plain add-half-and-mask rounding at bit 13
// instead of the full clipping conversion; write it only while no word is
// in flight.
module fp32_to_fp16_roundtrip_quantizer
  import fp2h_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  fp2h_in_if.sink    in_i,
  fp2h_out_if.source out_o
);

  logic        fast_mode_q;
  logic        s1_valid_q;
  logic        s1_fast_q;
  logic [31:0] s1_value_q;
  logic        s2_valid_q;
  logic [31:0] s2_result_q;

  logic        s2_load;
  logic        s1_load;
  half_t       half;
  logic [31:0] full_result;
  logic [18:0] fast_top;
  logic [31:0] result_d;

  assign s2_load    = !s2_valid_q || out_o.ready;
  assign s1_load    = !s1_valid_q || s2_load;
  assign in_i.ready = s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      fast_mode_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_i.valid) begin
      s1_value_q <= in_i.value_bits;
      s1_fast_q  <= fast_mode_q;
    end
  end

  fp2h_shrink u_shrink (
    .value_i (s1_value_q),
    .half_o  (half)
  );

  fp2h_expand u_expand (
    .half_i  (half),
    .value_o (full_result)
  );

  // Add half an LSB at bit 12 and drop the low bits; the carry wraps
  assign fast_top = s1_value_q[31:FastDropBits] + {18'd0, s1_value_q[FastDropBits-1]};
  assign result_d = s1_fast_q ? {fast_top, {FastDropBits{1'b0}}} : full_result;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_load) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load && s1_valid_q) begin
      s2_result_q <= result_d;
    end
  end

  assign out_o.valid       = s2_valid_q;
  assign out_o.result_bits = s2_result_q;

endmodule : fp32_to_fp16_roundtrip_quantizer
`default_nettype wire
